/* hw/rtl/bdq_pkg.sv */
package bdq_pkg;

  // Field widths of the input and result transfers.
  localparam int unsigned OpW       = 3;
  localparam int unsigned DataW     = 32;
  localparam int unsigned PosW      = 6;
  localparam int unsigned InBits    = OpW + DataW + PosW;
  localparam int unsigned InTdataW  = ((InBits + 7) / 8) * 8;

  // Operation codes carried in the op field.
  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_FIND       = 3'd6,
    OP_READ_AT    = 3'd7
  } op_e;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WAIT = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

endpackage

/* hw/rtl/bdq_ram.sv */
module bdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bounded_deque_with_search.sv */
// Double-ended queue of signed values held in a ring memory of DEPTH entries,
// with a linear search for the first position holding a given value.
//
// Input channel (s_axis): one transfer carries one operation: push front,
// push back, pop front, pop back, peek front, peek back, find, or read at a
// position counted from the front. Output channel (m_axis): every operation
// gives exactly one result transfer with an ok flag, the data read, the
// found position and the entry count after the operation.
//
// The block works on one operation at a time and drops s_axis_tready while
// it is busy. An accepted operation passes from IDLE through EXEC to DONE,
// where the result is loaded in the output register. A successful peek or
// read at goes through WAIT on the way for its registered memory read, and
// a find on a non-empty queue stays in SCAN while it compares entries; the
// compare unit checks one stored entry per cycle, and a search of a full
// queue compares up to DEPTH entries. The sequencer returns to idle on the
// edge that loads the result, and the next operation is accepted from there.
//
// The result sits in an output register; if m_axis_tready is low the block
// still completes the next operation and holds it until that register frees.
// Reset empties the queue at once; memory contents are not cleared.
module bounded_deque_with_search #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned CntW      = $clog2(DEPTH + 1),
  localparam int unsigned OutBits   = 1 + 32 + 6 + CntW,
  localparam int unsigned OutTdataW = ((OutBits + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // op [2:0], value [34:3], position [40:35], zero fill above
  input  logic [bdq_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // ok [0], data [32:1], found_position [38:33], count [38+CntW:39], zero fill
  output logic [OutTdataW-1:0]             m_axis_tdata
);

  import bdq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned SumW = CntW + 1;
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned FpW  = IdxW + PosW;

  // Unpacked input fields.
  logic [OpW-1:0]          in_op;
  logic signed [DataW-1:0] in_value;
  logic [PosW-1:0]         in_pos;

  assign in_op    = s_axis_tdata[OpW-1:0];
  assign in_value = signed'(s_axis_tdata[OpW+DataW-1:OpW]);
  assign in_pos   = s_axis_tdata[OpW+DataW+PosW-1:OpW+DataW];

  // Control state.
  state_e          state_q, state_d;
  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;

  // Operation and result working registers.
  op_e                   op_q, op_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [IdxW-1:0]       scan_idx_q, scan_idx_d;
  logic [IdxW-1:0]       scan_slot_q, scan_slot_d;
  logic                  res_ok_q, res_ok_d;
  logic [DataW-1:0]      res_data_q, res_data_d;
  logic [PosW-1:0]       res_fpos_q, res_fpos_d;
  logic                  out_ok_q, out_ok_d;
  logic [DataW-1:0]      out_data_q, out_data_d;
  logic [PosW-1:0]       out_fpos_q, out_fpos_d;
  logic [CntW-1:0]       out_count_q, out_count_d;

  // Memory port signals.
  logic                  ram_we;
  logic [IdxW-1:0]       ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  // Shared slot unit: ring slot of front plus an offset, wrapped once.
  logic [CntW-1:0] offset;
  logic [SumW-1:0] slot_sum;
  logic [IdxW-1:0] slot;
  logic            full;
  logic            empty;
  logic            pos_in_range;
  logic [IdxW-1:0] scan_next_slot;
  logic            scan_last;
  logic            scan_hit;
  logic [FpW-1:0]  fpos_wide;
  logic            in_xfer;
  logic            out_free;

  assign full         = (count_q == CntW'(DEPTH));
  assign empty        = (count_q == '0);
  assign pos_in_range = (CmpW'(pos_q) < CmpW'(count_q));

  always_comb begin
    case (op_q)
      OP_PUSH_FRONT: offset = CntW'(DEPTH - 1);
      OP_PUSH_BACK:  offset = count_q;
      OP_POP_FRONT:  offset = CntW'(1);
      OP_PEEK_BACK:  offset = count_q - 1'b1;
      OP_READ_AT:    offset = CntW'(pos_q);
      default:       offset = '0;
    endcase
  end

  assign slot_sum = SumW'(front_q) + SumW'(offset);
  assign slot     = (slot_sum >= SumW'(DEPTH)) ? IdxW'(slot_sum - SumW'(DEPTH))
                                               : IdxW'(slot_sum);

  // Scan walks the ring one slot per cycle; the compare sees last cycle's read.
  assign scan_next_slot = (scan_slot_q == IdxW'(DEPTH - 1)) ? '0 : scan_slot_q + 1'b1;
  assign scan_last      = (CntW'(scan_idx_q) == count_q - 1'b1);
  assign scan_hit       = (ram_rdata == value_q);
  assign fpos_wide      = FpW'(scan_idx_q);

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign ram_we    = (state_q == S_EXEC) && !full &&
                     ((op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK));
  assign ram_raddr = (state_q == S_EXEC) ? slot : scan_next_slot;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    op_d        = op_q;
    value_d     = value_q;
    pos_d       = pos_q;
    scan_idx_d  = scan_idx_q;
    scan_slot_d = scan_slot_q;
    res_ok_d    = res_ok_q;
    res_data_d  = res_data_q;
    res_fpos_d  = res_fpos_q;
    out_valid_d = out_valid_q;
    out_ok_d    = out_ok_q;
    out_data_d  = out_data_q;
    out_fpos_d  = out_fpos_q;
    out_count_d = out_count_q;

    // The output register empties on a result transfer.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d       = op_e'(in_op);
          value_d    = VALUE_BITS'(in_value);
          pos_d      = in_pos;
          res_ok_d   = 1'b0;
          res_data_d = '0;
          res_fpos_d = '0;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (op_q)
          OP_PUSH_FRONT: begin
            if (!full) begin
              front_d  = slot;
              count_d  = count_q + 1'b1;
              res_ok_d = 1'b1;
            end
          end
          OP_PUSH_BACK: begin
            if (!full) begin
              count_d  = count_q + 1'b1;
              res_ok_d = 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (!empty) begin
              front_d  = slot;
              count_d  = count_q - 1'b1;
              res_ok_d = 1'b1;
            end
          end
          OP_POP_BACK: begin
            if (!empty) begin
              count_d  = count_q - 1'b1;
              res_ok_d = 1'b1;
            end
          end
          OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (!empty) begin
              state_d = S_WAIT;
            end
          end
          OP_FIND: begin
            if (!empty) begin
              scan_idx_d  = '0;
              scan_slot_d = slot;
              state_d     = S_SCAN;
            end
          end
          default: begin
            if (pos_in_range) begin
              state_d = S_WAIT;
            end
          end
        endcase
      end
      S_WAIT: begin
        res_ok_d   = 1'b1;
        res_data_d = DataW'(ram_rdata);
        state_d    = S_DONE;
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_ok_d   = 1'b1;
          res_fpos_d = fpos_wide[PosW-1:0];
          state_d    = S_DONE;
        end else if (scan_last) begin
          state_d = S_DONE;
        end else begin
          scan_idx_d  = scan_idx_q + 1'b1;
          scan_slot_d = scan_next_slot;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_data_d  = res_data_q;
          out_fpos_d  = res_fpos_q;
          out_count_d = count_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    value_q     <= value_d;
    pos_q       <= pos_d;
    scan_idx_q  <= scan_idx_d;
    scan_slot_q <= scan_slot_d;
    res_ok_q    <= res_ok_d;
    res_data_q  <= res_data_d;
    res_fpos_q  <= res_fpos_d;
    out_ok_q    <= out_ok_d;
    out_data_q  <= out_data_d;
    out_fpos_q  <= out_fpos_d;
    out_count_q <= out_count_d;
  end

  // Ring storage.
  bdq_ram #(
    .Width (VALUE_BITS),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (value_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Channel outputs.
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'({out_count_q, out_fpos_q, out_data_q, out_ok_q});

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned ResTdataW  = 48;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainWait  = 80;

  // One result transfer, split into its fields.
  typedef struct packed {
    logic        ok;
    logic [31:0] data;
    logic [5:0]  found_pos;
    logic [6:0]  count;
  } deque_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // op [2:0], value [34:3], position [40:35], zero fill above
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // ok [0], data [32:1], found_position [38:33], count [45:39], zero fill
  logic [ResTdataW-1:0] m_axis_tdata;

  // Shadow copy of the ring store that predicts every result.
  logic [31:0]   shadow_mem [QueueDepth];
  logic [5:0]    shadow_front = '0;
  logic [6:0]    shadow_count = '0;
  deque_result_t pending_results [$];

  // Values that tend to collide, so that finds see duplicates.
  logic [31:0] hot_values [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h0000_0005, 32'h5555_5555, 32'hAAAA_AAAA};

  bit idle_enable = 1'b1;
  int mismatches = 0;
  int ops_sent = 0;
  int finds_hit = 0;
  int pushes_refused = 0;
  int empty_misses = 0;
  int peak_count = 0;
  int quiet_cycles = 0;

  bounded_deque_with_search i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    forever begin
      #2 clk_i = ~clk_i;
    end
  end

  // Apply one operation to the shadow store and return the result it must give.
  function automatic deque_result_t apply_deque_op(input op_e op, input logic [31:0] value,
                                                   input logic [5:0] position);
    deque_result_t res;
    logic [5:0]    slot;
    res = '0;
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_count < QueueDepth) begin
          shadow_front = shadow_front - 6'd1;
          shadow_mem[shadow_front] = value;
          shadow_count = shadow_count + 7'd1;
          res.ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count < QueueDepth) begin
          slot = shadow_front + shadow_count[5:0];
          shadow_mem[slot] = value;
          shadow_count = shadow_count + 7'd1;
          res.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count != 0) begin
          shadow_front = shadow_front + 6'd1;
          shadow_count = shadow_count - 7'd1;
          res.ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count != 0) begin
          shadow_count = shadow_count - 7'd1;
          res.ok = 1'b1;
        end
      end
      OP_PEEK_FRONT: begin
        if (shadow_count != 0) begin
          res.data = shadow_mem[shadow_front];
          res.ok = 1'b1;
        end
      end
      OP_PEEK_BACK: begin
        if (shadow_count != 0) begin
          slot = shadow_front + shadow_count[5:0] - 6'd1;
          res.data = shadow_mem[slot];
          res.ok = 1'b1;
        end
      end
      OP_FIND: begin
        // The first match from the front wins.
        for (int i = 0; i < shadow_count; i++) begin
          slot = shadow_front + 6'(i);
          if (!res.ok && shadow_mem[slot] == value) begin
            res.ok = 1'b1;
            res.found_pos = 6'(i);
          end
        end
      end
      default: begin
        if ({1'b0, position} < shadow_count) begin
          slot = shadow_front + position;
          res.data = shadow_mem[slot];
          res.ok = 1'b1;
        end
      end
    endcase
    res.count = shadow_count;
    return res;
  endfunction

  // Send one operation, with an occasional idle gap in front of it.
  task automatic send_op(input op_e op, input logic [31:0] value, input logic [5:0] position);
    int            gap;
    deque_result_t res;
    gap = 0;
    if (idle_enable && $urandom_range(99) < 6) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataW'({position, value, op});
    do @(posedge clk_i); while (!s_axis_tready);
    res = apply_deque_op(op, value, position);
    pending_results.push_back(res);
    ops_sent++;
    if (op == OP_FIND && res.ok) finds_hit++;
    if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && !res.ok) pushes_refused++;
    if (op inside {OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK} && !res.ok)
      empty_misses++;
    if (res.count > peak_count) peak_count = res.count;
  endtask

  // A value for a push or a find: mostly colliding or extreme values, some fully random.
  function automatic logic [31:0] pick_value();
    int unsigned r;
    logic [5:0]  slot;
    r = $urandom_range(99);
    if (r < 30 && shadow_count != 0) begin
      slot = shadow_front + 6'($urandom_range(shadow_count - 1));
      return shadow_mem[slot];
    end else if (r < 60) begin
      return hot_values[$urandom_range(7)];
    end
    return $urandom();
  endfunction

  // A position for read at: usually inside the held range.
  function automatic logic [5:0] pick_position();
    if (shadow_count != 0 && $urandom_range(99) < 70) return 6'($urandom_range(shadow_count - 1));
    return 6'($urandom_range(63));
  endfunction

  // Every lookup and removal against an empty store.
  task automatic test_empty_store();
    send_op(OP_POP_FRONT, 32'd0, 6'd0);
    send_op(OP_POP_BACK, 32'd0, 6'd0);
    send_op(OP_PEEK_FRONT, 32'd0, 6'd0);
    send_op(OP_PEEK_BACK, 32'd0, 6'd0);
    send_op(OP_FIND, 32'd0, 6'd0);
    send_op(OP_READ_AT, 32'd0, 6'd0);
  endtask

  // Extreme values pushed at both ends, then read back every way.
  task automatic test_extreme_values();
    send_op(OP_PUSH_BACK, 32'h7FFF_FFFF, 6'd0);
    send_op(OP_PUSH_FRONT, 32'h8000_0000, 6'd0);
    send_op(OP_PUSH_BACK, 32'hFFFF_FFFF, 6'd0);
    send_op(OP_PUSH_FRONT, 32'h0000_0000, 6'd0);
    send_op(OP_PEEK_FRONT, 32'd0, 6'd0);
    send_op(OP_PEEK_BACK, 32'd0, 6'd0);
    for (int i = 0; i < 5; i++) send_op(OP_READ_AT, 32'd0, 6'(i));
    send_op(OP_READ_AT, 32'd0, 6'd63);
    send_op(OP_FIND, 32'hFFFF_FFFF, 6'd0);
    send_op(OP_FIND, 32'h8000_0000, 6'd0);
    send_op(OP_FIND, 32'd12345, 6'd0);
    send_op(OP_POP_FRONT, 32'd0, 6'd0);
    send_op(OP_POP_BACK, 32'd0, 6'd0);
    send_op(OP_POP_FRONT, 32'd0, 6'd0);
    send_op(OP_POP_BACK, 32'd0, 6'd0);
  endtask

  // Fill the store to the top, knock on it while full, then drain past empty.
  task automatic test_fill_and_drain();
    while (shadow_count < QueueDepth) begin
      if ($urandom_range(99) < 10) begin
        send_op($urandom_range(1) ? OP_FIND : OP_READ_AT, pick_value(), pick_position());
      end else begin
        send_op($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value(), 6'd0);
      end
    end
    send_op(OP_PUSH_FRONT, $urandom(), 6'd0);
    send_op(OP_PUSH_BACK, $urandom(), 6'd0);
    send_op(OP_PEEK_FRONT, 32'd0, 6'd0);
    send_op(OP_PEEK_BACK, 32'd0, 6'd0);
    send_op(OP_READ_AT, 32'd0, 6'd63);
    send_op(OP_FIND, shadow_mem[shadow_front + 6'd63], 6'd0);
    send_op(OP_FIND, $urandom(), 6'd0);
    while (shadow_count != 0) begin
      send_op($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom(), 6'($urandom()));
    end
    send_op(OP_POP_BACK, 32'd0, 6'd0);
    send_op(OP_PEEK_FRONT, 32'd0, 6'd0);
  endtask

  // Random mix of operations; push_pct steers the occupancy up or down.
  task automatic test_random_ops(input int n_ops, input int push_pct);
    int unsigned r;
    op_e         op;
    for (int n = 0; n < n_ops; n++) begin
      r = $urandom_range(99);
      if (r < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else if (r < push_pct + (100 - push_pct) / 2) begin
        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      end else begin
        op = op_e'($urandom_range(OP_PEEK_FRONT, OP_READ_AT));
      end
      send_op(op, pick_value(), pick_position());
    end
  endtask

  // Result side: random back-pressure.
  initial begin
    forever begin
      @(posedge clk_i);
      m_axis_tready <= !(idle_enable && $urandom_range(99) < 6);
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    deque_result_t got;
    deque_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok        = m_axis_tdata[0];
      got.data      = m_axis_tdata[32:1];
      got.found_pos = m_axis_tdata[38:33];
      got.count     = m_axis_tdata[45:39];
      if (pending_results.size() == 0) begin
        $error("result transfer with no operation outstanding: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, got.ok);
          mismatches++;
        end
        if (got.data !== want.data) begin
          $error("data: expected %h, got %h", want.data, got.data);
          mismatches++;
        end
        if (got.found_pos !== want.found_pos) begin
          $error("found_position: expected %0d, got %0d", want.found_pos, got.found_pos);
          mismatches++;
        end
        if (got.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, got.count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: give up when no transfer happens on either side for too long.
  initial begin
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
             StallLimit, pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_extreme_values();
    test_fill_and_drain();
    test_random_ops(400, 60);
    test_random_ops(400, 40);
    // A long stretch with neither side idling.
    idle_enable = 1'b0;
    test_random_ops(300, 50);
    test_fill_and_drain();
    idle_enable = 1'b1;
    test_random_ops(300, 75);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Ran %0d operations: %0d finds hit, %0d pushes refused while full,",
             ops_sent, finds_hit, pushes_refused);
    $display("%0d pops or peeks on an empty store, peak occupancy %0d of %0d.",
             empty_misses, peak_count, QueueDepth);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
